// File: rtl/core/htw_pkg.sv
// Shared types and a constant function of the hierarchical timer wheel.
package htw_pkg;

  localparam int HANDLE_W = 6;
  localparam int TICKS_W  = 16;

  typedef struct packed {
    logic                tick;
    logic [HANDLE_W-1:0] handle;
    logic [TICKS_W-1:0]  delay;
    logic                periodic;
    logic [TICKS_W-1:0]  interval;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                rearmed;
    logic                last;
  } res_t;

  // Ticks spanned by one slot of a level; growth stops once past 32 bits.
  function automatic logic [63:0] span_of(input int slots, input int lvl);
    logic [63:0] s;
    s = 64'd1;
    for (int i = 0; i < 8; i++) begin
      if (i < lvl && s <= 64'hFFFF_FFFF) begin
        s = s * 64'(slots);
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/core/htw_front.sv
// Front end: accepts items, drops adds for handles outside the pool, queues the rest.
module htw_front #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            hold,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [htw_pkg::HANDLE_W-1:0]    in_task_handle,
  input  logic [htw_pkg::TICKS_W-1:0]     in_delay_ticks,
  input  logic                            in_periodic,
  input  logic [htw_pkg::TICKS_W-1:0]     in_interval_ticks,
  output logic                            q_valid,
  output htw_pkg::cmd_t                   q_item,
  input  logic                            q_ready
);

  htw_pkg::cmd_t q_mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          keep;
  logic          push;
  logic          pop;

  assign in_ready = (cnt_r != 2'd2) && !hold;
  assign keep     = in_command || (32'(in_task_handle) < 32'(POOL_ENTRIES));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{tick: in_command, handle: in_task_handle, delay: in_delay_ticks,
                         periodic: in_periodic, interval: in_interval_ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/htw_digit.sv
// Digit unit: repeated division of a 32-bit value by the slot count, four bits a cycle.
module htw_digit #(
  parameter int WHEEL_SLOTS  = 16,
  parameter int WHEEL_LEVELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [31:0]                            value,
  input  logic [$clog2(WHEEL_LEVELS+1)-1:0]      ndiv,
  output logic                                   busy,
  output logic                                   vld,
  output logic                                   done,
  output logic [$clog2(WHEEL_LEVELS+1)-1:0]      idx,
  output logic [$clog2(WHEEL_SLOTS)-1:0]         rem
);

  localparam int DW    = $clog2(WHEEL_SLOTS);
  localparam int NDW   = $clog2(WHEEL_LEVELS + 1);
  localparam int BPC   = 4;
  localparam int STEPS = 32 / BPC;

  logic           busy_r;
  logic [31:0]    x_r;
  logic [DW-1:0]  r_r;
  logic [2:0]     bcnt_r;
  logic [NDW-1:0] dcnt_r;
  logic [NDW-1:0] ndiv_r;
  logic           vld_r;
  logic [DW-1:0]  rem_r;
  logic [NDW-1:0] idx_r;
  logic [31:0]    xs;
  logic [DW-1:0]  rs;
  logic [DW:0]    r2;

  // Restoring long division; quotient bits shift in as dividend bits shift out.
  always_comb begin
    xs = x_r;
    rs = r_r;
    r2 = '0;
    for (int i = 0; i < BPC; i++) begin
      r2 = {rs, xs[31]};
      xs = {xs[30:0], 1'b0};
      if (r2 >= (DW+1)'(WHEEL_SLOTS)) begin
        r2    = r2 - (DW+1)'(WHEEL_SLOTS);
        xs[0] = 1'b1;
      end
      rs = r2[DW-1:0];
    end
  end

  assign busy = busy_r;
  assign vld  = vld_r;
  assign idx  = idx_r;
  assign rem  = rem_r;
  assign done = vld_r && (idx_r == ndiv_r - NDW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      vld_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= value;
        r_r    <= '0;
        bcnt_r <= 3'd0;
        dcnt_r <= '0;
        ndiv_r <= ndiv;
      end else if (busy_r) begin
        x_r    <= xs;
        r_r    <= rs;
        bcnt_r <= bcnt_r + 3'd1;
        if (bcnt_r == 3'(STEPS - 1)) begin
          vld_r <= 1'b1;
          rem_r <= rs;
          idx_r <= dcnt_r;
          r_r   <= '0;
          if (dcnt_r == ndiv_r - NDW'(1)) begin
            busy_r <= 1'b0;
          end else begin
            dcnt_r <= dcnt_r + NDW'(1);
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/htw_back.sv
// Back end: sequencer that owns the slot and entry memories and carries out adds and ticks.
module htw_back #(
  parameter int WHEEL_SLOTS  = 16,
  parameter int WHEEL_LEVELS = 4,
  parameter int POOL_ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          clearing,
  input  logic          q_valid,
  input  htw_pkg::cmd_t q_item,
  output logic          q_ready,
  output logic          oq_push,
  output htw_pkg::res_t oq_data,
  input  logic          oq_ready
);

  localparam int NSLOT  = WHEEL_SLOTS * WHEEL_LEVELS;
  localparam int SLW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int HW     = $clog2(POOL_ENTRIES);
  localparam int LW     = HW + 1;
  localparam int DW     = $clog2(WHEEL_SLOTS);
  localparam int NDW    = $clog2(WHEEL_LEVELS + 1);
  localparam int LVW    = (WHEEL_LEVELS > 1) ? $clog2(WHEEL_LEVELS) : 1;
  localparam int CLR_N  = (NSLOT > POOL_ENTRIES) ? NSLOT : POOL_ENTRIES;
  localparam int CW     = $clog2(CLR_N) + 1;
  localparam logic [LW-1:0] NIL = '1;
  localparam logic [31:0] TOPOFS =
    32'(htw_pkg::span_of(WHEEL_SLOTS, WHEEL_LEVELS) - 64'd1);

  localparam logic [4:0] ST_CLR    = 5'd0;
  localparam logic [4:0] ST_INIT   = 5'd1;
  localparam logic [4:0] ST_INITW  = 5'd2;
  localparam logic [4:0] ST_IDLE   = 5'd3;
  localparam logic [4:0] ST_ARD    = 5'd4;
  localparam logic [4:0] ST_ACHK   = 5'd5;
  localparam logic [4:0] ST_TINC   = 5'd6;
  localparam logic [4:0] ST_TDIG   = 5'd7;
  localparam logic [4:0] ST_TTOP   = 5'd8;
  localparam logic [4:0] ST_TCAS   = 5'd9;
  localparam logic [4:0] ST_TDET   = 5'd10;
  localparam logic [4:0] ST_TDET2  = 5'd11;
  localparam logic [4:0] ST_TNEXT  = 5'd12;
  localparam logic [4:0] ST_TENT   = 5'd13;
  localparam logic [4:0] ST_TADV   = 5'd14;
  localparam logic [4:0] ST_PSTART = 5'd15;
  localparam logic [4:0] ST_PDIV   = 5'd16;
  localparam logic [4:0] ST_PLINK  = 5'd17;
  localparam logic [4:0] ST_PLINK2 = 5'd18;
  localparam logic [4:0] ST_EMIT   = 5'd19;
  localparam logic [4:0] ST_FIN    = 5'd20;

  typedef struct packed {
    logic [31:0]                   expiry;
    logic [htw_pkg::TICKS_W-1:0]   interval;
    logic                          periodic;
    logic [LW-1:0]                 link;
    logic                          pending;
  } ent_t;

  logic [LW-1:0] slot_mem [NSLOT];
  ent_t          ent_mem  [POOL_ENTRIES];

  logic [4:0]          state_r;
  logic [31:0]         tc_r;
  logic [DW-1:0]       dig_r [WHEEL_LEVELS];
  logic [DW-1:0]       top_dig_r;
  logic [LVW-1:0]      lvl_r;
  logic                walk_r;
  htw_pkg::cmd_t       cmd_r;
  logic [HW-1:0]       h_r;
  logic [LW-1:0]       cur_h_r;
  logic [LW-1:0]       next_h_r;
  ent_t                ent_r;
  logic [SLW-1:0]      slot_r;
  logic [4:0]          pret_r;
  logic [4:0]          eret_r;
  logic [HW-1:0]       emit_h_r;
  logic                emit_re_r;
  htw_pkg::res_t       held_r;
  logic                held_v_r;
  logic [CW-1:0]       clr_cnt_r;

  logic                sm_we;
  logic [SLW-1:0]      sm_wa;
  logic [LW-1:0]       sm_wd;
  logic [LW-1:0]       sm_rd_r;
  logic                em_we;
  logic [HW-1:0]       em_wa;
  ent_t                em_wd;
  logic [HW-1:0]       em_ra;
  ent_t                em_rd_r;

  logic                div_start;
  logic [31:0]         div_value;
  logic [NDW-1:0]      div_ndiv;
  logic                div_busy;
  logic                div_vld;
  logic                div_done;
  logic [NDW-1:0]      div_idx;
  logic [DW-1:0]       div_rem;

  logic [31:0]         pd;
  logic                p_due;
  logic                p_found;
  logic [LVW-1:0]      p_lvl;
  logic [31:0]         rd_d;
  logic                rd_due;
  logic                low_zero;
  logic [htw_pkg::TICKS_W-1:0] add_ivl;
  logic                emit_go;

  htw_digit #(
    .WHEEL_SLOTS  (WHEEL_SLOTS),
    .WHEEL_LEVELS (WHEEL_LEVELS)
  ) u_digit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (div_value),
    .ndiv  (div_ndiv),
    .busy  (div_busy),
    .vld   (div_vld),
    .done  (div_done),
    .idx   (div_idx),
    .rem   (div_rem)
  );

  // Placement: the lowest level whose span covers the remaining delay.
  always_comb begin
    pd      = ent_r.expiry - tc_r;
    p_due   = (pd == 32'd0) || pd[31];
    p_found = 1'b0;
    p_lvl   = '0;
    for (int k = 0; k < WHEEL_LEVELS; k++) begin
      if (!p_found && ({32'd0, pd} < htw_pkg::span_of(WHEEL_SLOTS, k + 1))) begin
        p_found = 1'b1;
        p_lvl   = LVW'(k);
      end
    end
  end

  always_comb begin
    rd_d     = em_rd_r.expiry - tc_r;
    rd_due   = (rd_d == 32'd0) || rd_d[31];
    low_zero = 1'b1;
    for (int k = 0; k < WHEEL_LEVELS; k++) begin
      if ((k < int'(lvl_r)) && (dig_r[k] != '0)) begin
        low_zero = 1'b0;
      end
    end
    add_ivl = (cmd_r.interval == '0) ? htw_pkg::TICKS_W'(1) : cmd_r.interval;
  end

  always_comb begin
    div_start = 1'b0;
    div_value = tc_r;
    div_ndiv  = NDW'(WHEEL_LEVELS);
    unique case (state_r)
      ST_INIT: begin
        div_start = !div_busy;
        div_value = TOPOFS;
      end
      ST_TINC: begin
        div_start = 1'b1;
        div_value = tc_r + 32'd1;
      end
      ST_TDIG: begin
        div_start = div_done;
        div_value = tc_r + TOPOFS;
      end
      ST_PSTART: begin
        div_start = !p_due && p_found;
        div_value = ent_r.expiry;
        div_ndiv  = NDW'(p_lvl) + NDW'(1);
      end
      default: begin
      end
    endcase
  end

  assign emit_go  = !held_v_r || oq_ready;
  assign oq_push  = held_v_r && oq_ready && ((state_r == ST_EMIT) || (state_r == ST_FIN));
  assign oq_data  = '{handle: held_r.handle, rearmed: held_r.rearmed,
                      last: (state_r == ST_FIN)};
  assign q_ready  = (state_r == ST_IDLE);
  assign clearing = (state_r == ST_CLR) || (state_r == ST_INIT) || (state_r == ST_INITW);

  always_comb begin
    sm_we = 1'b0;
    sm_wa = slot_r;
    sm_wd = NIL;
    em_we = 1'b0;
    em_wa = h_r;
    em_wd = ent_r;
    em_ra = cur_h_r[HW-1:0];
    unique case (state_r)
      ST_CLR: begin
        sm_we = (32'(clr_cnt_r) < 32'(NSLOT));
        sm_wa = clr_cnt_r[SLW-1:0];
        em_we = (32'(clr_cnt_r) < 32'(POOL_ENTRIES));
        em_wa = clr_cnt_r[HW-1:0];
        em_wd = '0;
      end
      ST_ARD: begin
        em_ra = HW'(cmd_r.handle);
      end
      ST_TDET2: begin
        sm_we = 1'b1;
      end
      ST_PLINK2: begin
        sm_we = 1'b1;
        sm_wd = LW'(h_r);
        em_we = 1'b1;
        em_wd = '{expiry: ent_r.expiry, interval: ent_r.interval, periodic: ent_r.periodic,
                  link: sm_rd_r, pending: ent_r.pending};
      end
      ST_TENT: begin
        // A one-shot task that is due leaves the pool.
        em_we = walk_r && rd_due && !em_rd_r.periodic;
        em_wa = cur_h_r[HW-1:0];
        em_wd = '{expiry: em_rd_r.expiry, interval: em_rd_r.interval, periodic: 1'b0,
                  link: em_rd_r.link, pending: 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      slot_mem[sm_wa] <= sm_wd;
    end
    sm_rd_r <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (em_we) begin
      ent_mem[em_wa] <= em_wd;
    end
    em_rd_r <= ent_mem[em_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
      tc_r      <= 32'd0;
      held_v_r  <= 1'b0;
      for (int k = 0; k < WHEEL_LEVELS; k++) begin
        dig_r[k] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
          if (clr_cnt_r == CW'(CLR_N - 1)) begin
            state_r <= ST_INIT;
          end
        end
        ST_INIT: begin
          if (!div_busy) begin
            state_r <= ST_INITW;
          end
        end
        ST_INITW: begin
          if (div_done) begin
            top_dig_r <= div_rem;
            state_r   <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_item;
            state_r <= q_item.tick ? ST_TINC : ST_ARD;
          end
        end
        ST_ARD: begin
          state_r <= ST_ACHK;
        end
        ST_ACHK: begin
          if (em_rd_r.pending) begin
            state_r <= ST_FIN;
          end else begin
            h_r            <= HW'(cmd_r.handle);
            ent_r.interval <= add_ivl;
            ent_r.periodic <= cmd_r.periodic;
            ent_r.pending  <= 1'b1;
            pret_r         <= ST_FIN;
            if (cmd_r.delay == '0) begin
              emit_h_r  <= HW'(cmd_r.handle);
              emit_re_r <= cmd_r.periodic;
              ent_r.expiry <= tc_r + 32'(add_ivl);
              eret_r    <= cmd_r.periodic ? ST_PSTART : ST_FIN;
              state_r   <= ST_EMIT;
            end else begin
              ent_r.expiry <= tc_r + 32'(cmd_r.delay);
              state_r      <= ST_PSTART;
            end
          end
        end
        ST_TINC: begin
          tc_r    <= tc_r + 32'd1;
          state_r <= ST_TDIG;
        end
        ST_TDIG: begin
          if (div_vld) begin
            dig_r[div_idx[LVW-1:0]] <= div_rem;
          end
          if (div_done) begin
            state_r <= ST_TTOP;
          end
        end
        ST_TTOP: begin
          if (div_done) begin
            top_dig_r <= div_rem;
            lvl_r     <= LVW'(WHEEL_LEVELS - 1);
            state_r   <= ST_TCAS;
          end
        end
        ST_TCAS: begin
          // Higher levels cascade first, then the current level-0 slot is walked.
          if (lvl_r == '0) begin
            walk_r  <= 1'b1;
            slot_r  <= SLW'(dig_r[0]);
            state_r <= ST_TDET;
          end else if (low_zero) begin
            walk_r  <= 1'b0;
            slot_r  <= SLW'(int'(lvl_r) * WHEEL_SLOTS) + SLW'(dig_r[lvl_r]);
            state_r <= ST_TDET;
          end else begin
            lvl_r <= lvl_r - LVW'(1);
          end
        end
        ST_TDET: begin
          state_r <= ST_TDET2;
        end
        ST_TDET2: begin
          cur_h_r <= sm_rd_r;
          state_r <= ST_TNEXT;
        end
        ST_TNEXT: begin
          if (32'(cur_h_r) >= 32'(POOL_ENTRIES)) begin
            if (walk_r) begin
              state_r <= ST_FIN;
            end else begin
              lvl_r   <= lvl_r - LVW'(1);
              state_r <= ST_TCAS;
            end
          end else begin
            state_r <= ST_TENT;
          end
        end
        ST_TENT: begin
          h_r      <= cur_h_r[HW-1:0];
          next_h_r <= em_rd_r.link;
          ent_r    <= em_rd_r;
          emit_h_r <= cur_h_r[HW-1:0];
          eret_r   <= ST_TADV;
          if (walk_r && rd_due) begin
            emit_re_r <= em_rd_r.periodic;
            if (em_rd_r.periodic) begin
              ent_r.expiry <= em_rd_r.expiry + 32'(em_rd_r.interval);
              pret_r       <= ST_EMIT;
              state_r      <= ST_PSTART;
            end else begin
              state_r <= ST_EMIT;
            end
          end else begin
            pret_r  <= ST_TADV;
            state_r <= ST_PSTART;
          end
        end
        ST_TADV: begin
          cur_h_r <= next_h_r;
          state_r <= ST_TNEXT;
        end
        ST_PSTART: begin
          if (p_due) begin
            slot_r  <= SLW'(dig_r[0]);
            state_r <= ST_PLINK;
          end else if (p_found) begin
            slot_r  <= SLW'(int'(p_lvl) * WHEEL_SLOTS);
            state_r <= ST_PDIV;
          end else begin
            // Beyond the whole range: the top-level slot that is walked last.
            slot_r  <= SLW'((WHEEL_LEVELS - 1) * WHEEL_SLOTS) + SLW'(top_dig_r);
            state_r <= ST_PLINK;
          end
        end
        ST_PDIV: begin
          if (div_done) begin
            slot_r  <= slot_r + SLW'(div_rem);
            state_r <= ST_PLINK;
          end
        end
        ST_PLINK: begin
          state_r <= ST_PLINK2;
        end
        ST_PLINK2: begin
          state_r <= pret_r;
        end
        ST_EMIT: begin
          // The newest result is held back so that the final one can be marked.
          if (emit_go) begin
            held_r   <= '{handle: htw_pkg::HANDLE_W'(emit_h_r), rearmed: emit_re_r,
                          last: 1'b0};
            held_v_r <= 1'b1;
            state_r  <= eret_r;
          end
        end
        ST_FIN: begin
          if (!held_v_r) begin
            state_r <= ST_IDLE;
          end else if (oq_ready) begin
            held_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/htw_outq.sv
// Result queue: two-entry buffer between the sequencer and the result channel.
module htw_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htw_pkg::res_t push_data,
  output logic          push_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output htw_pkg::res_t out_data
);

  htw_pkg::res_t mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          pop;
  logic          wr;

  assign push_ready = (cnt_r != 2'd2);
  assign wr         = push && push_ready;
  assign out_valid  = (cnt_r != 2'd0);
  assign out_data   = mem_r[rp_r];
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (wr && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/hierarchical_timer_wheel_core.sv
// Hierarchical timer wheel: a two-item command queue feeds a sequencer that owns the
// wheel's slot and entry memories, and results leave through a two-item queue. After
// reset the block takes no item while it clears the slot heads and pending flags, and
// then while it works out the position of the overflow slot. An add checks the entry
// for a pending handle, and a digit division selects its slot when the delay falls
// within a level's span. A tick derives the counter digits, checks each level for
// cascade from the top down and walks the entries of the slots it visits; the shared
// four-bit-per-cycle divider and the memories, each with one read and one write port,
// set the pace of this work.
module hierarchical_timer_wheel_core #(
  parameter int WHEEL_SLOTS  = 16,
  parameter int WHEEL_LEVELS = 4,
  parameter int POOL_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [htw_pkg::HANDLE_W-1:0]  in_task_handle,
  input  logic [htw_pkg::TICKS_W-1:0]   in_delay_ticks,
  input  logic                          in_periodic,
  input  logic [htw_pkg::TICKS_W-1:0]   in_interval_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htw_pkg::HANDLE_W-1:0]  out_expired_handle,
  output logic                          out_rearmed,
  output logic                          out_last_of_run
);

  logic          clearing;
  logic          q_valid;
  htw_pkg::cmd_t q_item;
  logic          q_ready;
  logic          oq_push;
  htw_pkg::res_t oq_data;
  logic          oq_ready;
  htw_pkg::res_t out_data;

  htw_front #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .hold              (clearing),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_task_handle    (in_task_handle),
    .in_delay_ticks    (in_delay_ticks),
    .in_periodic       (in_periodic),
    .in_interval_ticks (in_interval_ticks),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_ready           (q_ready)
  );

  htw_back #(
    .WHEEL_SLOTS  (WHEEL_SLOTS),
    .WHEEL_LEVELS (WHEEL_LEVELS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready),
    .oq_push  (oq_push),
    .oq_data  (oq_data),
    .oq_ready (oq_ready)
  );

  htw_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (oq_push),
    .push_data  (oq_data),
    .push_ready (oq_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_expired_handle = out_data.handle;
  assign out_rearmed        = out_data.rearmed;
  assign out_last_of_run    = out_data.last;

endmodule

// File: tb/hierarchical_timer_wheel_checker.sv
// Checker for the timer wheel: predicts the expiries of each accepted item and compares them.
module hierarchical_timer_wheel_checker #(
  parameter int SLOTS  = 16,
  parameter int LEVELS = 4,
  parameter int POOL   = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_command,
  input  logic [htw_pkg::HANDLE_W-1:0] in_task_handle,
  input  logic [htw_pkg::TICKS_W-1:0]  in_delay_ticks,
  input  logic                         in_periodic,
  input  logic [htw_pkg::TICKS_W-1:0]  in_interval_ticks,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [htw_pkg::HANDLE_W-1:0] out_expired_handle,
  input  logic                         out_rearmed,
  input  logic                         out_last_of_run,
  output int                           fail_count,
  output int                           expiries_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import htw_pkg::*;

  localparam logic [6:0] NO_ENTRY = 7'd127;
  localparam int MAX_EXPIRIES = 64;

  logic [31:0] now_tick;
  logic [6:0]  list_head [SLOTS*LEVELS];
  logic [31:0] due_tick [POOL];
  logic [15:0] period [POOL];
  logic        repeats [POOL];
  logic [6:0]  next_in_list [POOL];
  logic        armed [POOL];
  res_t        expiry_q [$];
  int          run_len;

  function automatic logic [63:0] ticks_per_slot(int lvl);
    logic [63:0] s;
    s = 64'd1;
    for (int i = 0; i < lvl; i++) begin
      if (s <= 64'hFFFF_FFFF) s = s * SLOTS;
    end
    return s;
  endfunction

  function automatic int slot_digit(logic [31:0] x, int lvl);
    return int'((64'(x) / ticks_per_slot(lvl)) % SLOTS);
  endfunction

  function automatic logic has_come(logic [31:0] at);
    logic [31:0] d;
    d = at - now_tick;
    return (d == 0) || d[31];
  endfunction

  task automatic push_front(int slot, int h);
    next_in_list[h] = list_head[slot];
    list_head[slot] = 7'(h);
  endtask

  task automatic file_entry(int h);
    logic [31:0] d;
    d = due_tick[h] - now_tick;
    if (has_come(due_tick[h])) begin
      push_front(slot_digit(now_tick, 0), h);
      return;
    end
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      if (64'(d) < ticks_per_slot(lvl + 1)) begin
        push_front(lvl * SLOTS + slot_digit(due_tick[h], lvl), h);
        return;
      end
    end
    // Too far out for every level: park in the top-level slot reached last.
    push_front((LEVELS - 1) * SLOTS +
               slot_digit(now_tick + 32'(ticks_per_slot(LEVELS) - 1), LEVELS - 1), h);
  endtask

  task automatic add_expiry(int h, logic rearm);
    res_t r;
    if (run_len >= MAX_EXPIRIES) return;
    r.handle  = HANDLE_W'(h);
    r.rearmed = rearm;
    r.last    = 1'b0;
    expiry_q.push_back(r);
    run_len++;
  endtask

  task automatic predict_item();
    int h, nxt;
    logic [15:0] ivl;
    run_len = 0;
    if (!in_command) begin
      h = int'(in_task_handle);
      if (h >= POOL || armed[h]) return;
      ivl = (in_interval_ticks == 0) ? 16'd1 : in_interval_ticks;
      period[h]  = ivl;
      repeats[h] = in_periodic;
      armed[h]   = 1'b1;
      if (in_delay_ticks == 0) begin
        add_expiry(h, in_periodic);
        if (in_periodic) begin
          due_tick[h] = now_tick + ivl;
          file_entry(h);
        end else begin
          armed[h] = 1'b0;
        end
      end else begin
        due_tick[h] = now_tick + in_delay_ticks;
        file_entry(h);
      end
    end else begin
      now_tick = now_tick + 1;
      for (int lvl = LEVELS - 1; lvl >= 1; lvl--) begin
        if (64'(now_tick) % ticks_per_slot(lvl) == 0) begin
          h = int'(list_head[lvl * SLOTS + slot_digit(now_tick, lvl)]);
          list_head[lvl * SLOTS + slot_digit(now_tick, lvl)] = NO_ENTRY;
          while (h < POOL) begin
            nxt = int'(next_in_list[h]);
            file_entry(h);
            h = nxt;
          end
        end
      end
      h = int'(list_head[slot_digit(now_tick, 0)]);
      list_head[slot_digit(now_tick, 0)] = NO_ENTRY;
      while (h < POOL) begin
        nxt = int'(next_in_list[h]);
        if (has_come(due_tick[h])) begin
          if (repeats[h]) begin
            due_tick[h] = due_tick[h] + period[h];
            file_entry(h);
            add_expiry(h, 1'b1);
          end else begin
            armed[h] = 1'b0;
            add_expiry(h, 1'b0);
          end
        end else begin
          file_entry(h);
        end
        h = nxt;
      end
    end
    if (run_len > 0) expiry_q[expiry_q.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what);
    $display("checker: mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    expiries_waiting = 0;
    now_tick = '0;
    foreach (list_head[i]) list_head[i] = NO_ENTRY;
    foreach (armed[i]) begin
      armed[i] = 1'b0;
      due_tick[i] = '0;
      period[i] = '0;
      repeats[i] = 1'b0;
      next_in_list[i] = '0;
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (in_valid && in_ready) predict_item();
      if (out_valid && out_ready) begin
        if (expiry_q.size() == 0) begin
          report($sformatf("unexpected expiry of handle %0d", out_expired_handle));
        end else begin
          e = expiry_q.pop_front();
          if (out_expired_handle !== e.handle)
            report($sformatf("handle %0d, expected %0d", out_expired_handle, e.handle));
          if (out_rearmed !== e.rearmed)
            report($sformatf("rearmed %b for handle %0d, expected %b",
                             out_rearmed, e.handle, e.rearmed));
          if (out_last_of_run !== e.last)
            report($sformatf("last_of_run %b for handle %0d, expected %b",
                             out_last_of_run, e.handle, e.last));
        end
      end
      expiries_waiting = expiry_q.size();
    end
  end

endmodule

// File: tb/hierarchical_timer_wheel_core_tb.sv
// Top of the timer wheel testbench: clock, reset, stimulus, receiver stalls and verdict.
module hierarchical_timer_wheel_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htw_pkg::*;

  localparam int IDLE_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 160;
  localparam int CHOKE_CYCLES = 2500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = 1'b0;
  logic [HANDLE_W-1:0] in_task_handle = '0;
  logic [TICKS_W-1:0]  in_delay_ticks = '0;
  logic                in_periodic = 1'b0;
  logic [TICKS_W-1:0]  in_interval_ticks = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [HANDLE_W-1:0] out_expired_handle;
  logic                out_rearmed;
  logic                out_last_of_run;
  int                  fail_count;
  int                  expiries_waiting;

  int  burst_left = 0;
  int  items_sent = 0;
  logic choke_req = 1'b0;
  int  idle_cycles = 0;

  hierarchical_timer_wheel_core i_dut (.*);

  hierarchical_timer_wheel_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: now and then picks one of three stall habits at random; once holds off for long.
  always @(posedge clk) begin
    static int cyc = 0;
    static int choke_left = -1;
    static int habit = 0;
    cyc++;
    if (cyc % 400 == 0) habit = $urandom_range(0, 2);
    if (choke_req && choke_left < 0) choke_left = CHOKE_CYCLES;
    if (choke_left > 0) begin
      choke_left--;
      out_ready <= 1'b0;
    end else if (habit == 0) begin
      out_ready <= 1'b1;
    end else if (habit == 1) begin
      out_ready <= $urandom_range(0, 1);
    end else begin
      out_ready <= (cyc % 7) >= 3;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send(logic cmd, int h, int dly, logic per, int ivl);
    int gap;
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_task_handle    <= HANDLE_W'(h);
    in_delay_ticks    <= TICKS_W'(dly);
    in_periodic       <= per;
    in_interval_ticks <= TICKS_W'(ivl);
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_tick();
    send(1'b1, $urandom_range(0, 63), $urandom_range(0, 65535), $urandom_range(0, 1),
         $urandom_range(0, 65535));
  endtask

  task automatic send_random();
    int dly, ivl, pick;
    if ($urandom_range(0, 99) < 55) begin
      send_tick();
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) dly = 0;
      else if (pick <= 7) dly = $urandom_range(1, 40);
      else dly = $urandom_range(0, 65535);
      pick = $urandom_range(0, 9);
      if (pick == 0) ivl = 0;
      else if (pick <= 7) ivl = $urandom_range(1, 20);
      else ivl = $urandom_range(1, 65535);
      send(1'b0, $urandom_range(0, 63), dly, $urandom_range(0, 3) == 0, ivl);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Immediate expiry, one-shot and periodic with an interval of zero.
    send(1'b0, 0, 0, 1'b0, 5);
    send(1'b0, 63, 0, 1'b1, 0);
    // An add for a handle that is still armed is ignored.
    send(1'b0, 63, 3, 1'b0, 1);
    send(1'b0, 1, 1, 1'b0, 1);
    send(1'b0, 2, 15, 1'b1, 16);
    send(1'b0, 3, 16, 1'b0, 1);
    send(1'b0, 4, 17, 1'b1, 2);
    send(1'b0, 5, 65535, 1'b1, 65535);
    send(1'b0, 42, 21845, 1'b0, 43690);
    send(1'b0, 21, 43690, 1'b1, 21845);
    send(1'b0, 6, 256, 1'b0, 1);
    repeat (14) send_tick();

    while (items_sent < 25 + RANDOM_ITEMS) begin
      if (items_sent == 80) choke_req <= 1'b1;
      send_random();
    end
    in_valid <= 1'b0;

    while (expiries_waiting != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/htw_pkg.sv
rtl/core/htw_front.sv
rtl/core/htw_digit.sv
rtl/core/htw_back.sv
rtl/core/htw_outq.sv
rtl/core/hierarchical_timer_wheel_core.sv
tb/hierarchical_timer_wheel_checker.sv
tb/hierarchical_timer_wheel_core_tb.sv
